// ----- rtl/core/lcdseq_pkg.sv -----
package lcdseq_pkg;

    localparam int PC_W = 5;

    // operations
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_NUMBER = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_POWER_WAIT   = 2'd1;
    localparam logic [1:0] CFG_EIGHT_BIT    = 2'd2;

    localparam logic [15:0] RST_POWER_WAIT = 16'd35000;
    localparam logic [15:0] WAIT_SHORT_US  = 16'd42;
    localparam logic [15:0] WAIT_CLEAR_US  = 16'd1600;

    localparam logic [7:0] LCD_FUNC_4BIT = 8'b0010_1000;
    localparam logic [7:0] LCD_DISP_ON   = 8'b0000_1111;
    localparam logic [7:0] LCD_CLEAR     = 8'b0000_0001;
    localparam logic [7:0] LCD_ENTRY     = 8'b0000_0110;
    localparam logic [7:0] LCD_FUNC_8BIT = 8'b0011_1000;
    localparam logic [7:0] LCD_MODE_NIB  = 8'b0000_0010;
    localparam logic [7:0] LCD_LINE1     = 8'h80;
    localparam logic [7:0] LCD_LINE2     = 8'hC0;
    localparam logic [3:0] ASCII_DIG_HI  = 4'h3;

    // floor(n / 10) = (n * DIV10_RECIP) >> DIV10_SHIFT, exact for 32-bit n
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // byte sources
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_BYTE  = 2'd1;
    localparam logic [1:0] SRC_DIGIT = 2'd2;

    // wait sources
    localparam logic [1:0] WT_ZERO  = 2'd0;
    localparam logic [1:0] WT_POWER = 2'd1;
    localparam logic [1:0] WT_SHORT = 2'd2;
    localparam logic [1:0] WT_CLEAR = 2'd3;

    // jump conditions
    localparam logic [2:0] C_NONE      = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_EIGHT     = 3'd2;
    localparam logic [2:0] C_CONV_MORE = 3'd3;
    localparam logic [2:0] C_DIG_MORE  = 3'd4;

    // digit unit actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_MUL  = 2'd1;
    localparam logic [1:0] ACT_DIV  = 2'd2;
    localparam logic [1:0] ACT_POP  = 2'd3;

    // program entry points
    localparam logic [PC_W-1:0] A_INIT   = 5'd0;
    localparam logic [PC_W-1:0] A_INIT4  = 5'd1;
    localparam logic [PC_W-1:0] A_INIT8  = 5'd4;
    localparam logic [PC_W-1:0] A_DISPON = 5'd6;
    localparam logic [PC_W-1:0] A_CMD    = 5'd12;
    localparam logic [PC_W-1:0] A_CHAR   = 5'd14;
    localparam logic [PC_W-1:0] A_NUM    = 5'd16;
    localparam logic [PC_W-1:0] A_DIGHI  = 5'd18;
    localparam logic [PC_W-1:0] A_NULL   = 5'd20;

    typedef struct packed {
        logic            emit;
        logic            hi;
        logic [1:0]      src;
        logic [7:0]      konst;
        logic [1:0]      wt;
        logic            rs;
        logic            last;
        logic            endp;
        logic [2:0]      cond;
        logic [1:0]      act;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic pop;
    } t_dig_ctl;

    typedef struct packed {
        logic       conv_more;
        logic       dig_more;
        logic [3:0] digit;
    } t_dig_sts;

    function automatic t_uword uw(input logic emit, input logic hi, input logic [1:0] src,
                                  input logic [7:0] konst, input logic [1:0] wt,
                                  input logic rs, input logic last, input logic endp,
                                  input logic [2:0] cond, input logic [1:0] act,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.emit   = emit;
        w.hi     = hi;
        w.src    = src;
        w.konst  = konst;
        w.wt     = wt;
        w.rs     = rs;
        w.last   = last;
        w.endp   = endp;
        w.cond   = cond;
        w.act    = act;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(1'b0, 1'b0, SRC_CONST, 8'h00, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_EIGHT, ACT_NONE, A_INIT8);
            5'd1:  w = uw(1'b1, 1'b0, SRC_CONST, LCD_MODE_NIB, WT_POWER, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd2:  w = uw(1'b1, 1'b1, SRC_CONST, LCD_FUNC_4BIT, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd3:  w = uw(1'b1, 1'b0, SRC_CONST, LCD_FUNC_4BIT, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_ALWAYS, ACT_NONE, A_DISPON);
            5'd4:  w = uw(1'b1, 1'b1, SRC_CONST, LCD_FUNC_8BIT, WT_POWER, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd5:  w = uw(1'b1, 1'b0, SRC_CONST, LCD_FUNC_8BIT, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd6:  w = uw(1'b1, 1'b1, SRC_CONST, LCD_DISP_ON, WT_SHORT, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd7:  w = uw(1'b1, 1'b0, SRC_CONST, LCD_DISP_ON, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd8:  w = uw(1'b1, 1'b1, SRC_CONST, LCD_CLEAR, WT_SHORT, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd9:  w = uw(1'b1, 1'b0, SRC_CONST, LCD_CLEAR, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd10: w = uw(1'b1, 1'b1, SRC_CONST, LCD_ENTRY, WT_CLEAR, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd11: w = uw(1'b1, 1'b0, SRC_CONST, LCD_ENTRY, WT_ZERO, 1'b0, 1'b1, 1'b1,
                          C_NONE, ACT_NONE, A_NULL);
            5'd12: w = uw(1'b1, 1'b1, SRC_BYTE, 8'h00, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd13: w = uw(1'b1, 1'b0, SRC_BYTE, 8'h00, WT_ZERO, 1'b0, 1'b1, 1'b1,
                          C_NONE, ACT_NONE, A_NULL);
            5'd14: w = uw(1'b1, 1'b1, SRC_BYTE, 8'h00, WT_ZERO, 1'b1, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd15: w = uw(1'b1, 1'b0, SRC_BYTE, 8'h00, WT_ZERO, 1'b1, 1'b1, 1'b1,
                          C_NONE, ACT_NONE, A_NULL);
            5'd16: w = uw(1'b0, 1'b0, SRC_CONST, 8'h00, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_NONE, ACT_MUL, A_NULL);
            5'd17: w = uw(1'b0, 1'b0, SRC_CONST, 8'h00, WT_ZERO, 1'b0, 1'b0, 1'b0,
                          C_CONV_MORE, ACT_DIV, A_NUM);
            5'd18: w = uw(1'b1, 1'b1, SRC_DIGIT, 8'h00, WT_ZERO, 1'b1, 1'b0, 1'b0,
                          C_NONE, ACT_NONE, A_NULL);
            5'd19: w = uw(1'b1, 1'b0, SRC_DIGIT, 8'h00, WT_ZERO, 1'b1, 1'b1, 1'b1,
                          C_DIG_MORE, ACT_POP, A_DIGHI);
            default: w = uw(1'b0, 1'b0, SRC_CONST, 8'h00, WT_ZERO, 1'b0, 1'b0, 1'b1,
                            C_NONE, ACT_NONE, A_NULL);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/lcdseq_digits.sv -----
module lcdseq_digits import lcdseq_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_number_value,
    input  t_dig_ctl    i_ctl,
    output t_dig_sts    o_sts
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [31:0]   r_num;
    logic [31:0]   r_quot;
    logic [CW-1:0] r_count;
    logic [3:0]    r_stack [MAX_DIGITS];

    logic [63:0] w_prod;
    logic [31:0] w_q10;
    logic [3:0]  w_rem;

    assign w_prod = {32'd0, r_num} * {32'd0, DIV10_RECIP};
    assign w_q10  = (r_quot << 3) + (r_quot << 1);
    assign w_rem  = 4'(r_num - w_q10);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= i_number_value;
        end else if (i_ctl.mul) begin
            r_quot <= 32'(w_prod[63:DIV10_SHIFT]);
        end else if (i_ctl.div) begin
            r_num <= r_quot;
        end
    end

    // digit stack, top at entry 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.div) begin
            r_stack[0] <= w_rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_ctl.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.load) begin
            r_count <= '0;
        end else if (i_ctl.div) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_sts.conv_more = (r_quot != 32'd0) &&
                             ((CW+1)'(r_count) + (CW+1)'(1) < (CW+1)'(MAX_DIGITS));
    assign o_sts.dig_more  = r_count > CW'(1);
    assign o_sts.digit     = r_stack[0];

endmodule

// ----- rtl/core/char_lcd_nibble_sequencer.sv -----
// Character LCD nibble sequencer. Pulse start while busy is low to hand over one request;
// strobes then follow on o_strobe, one per cycle where the program emits, each valid for
// exactly one cycle, and the receiver cannot stall them, so it must take every strobe as
// it comes. o_last marks the final strobe; busy falls with it and a new request may start
// in the same cycle. Timing is set by a microcode program with one step per cycle: init
// runs its 8-bit or 4-bit sequence, command, character and cursor move send one byte, a
// cursor move out of range or an unknown operation ends with no strobe, and a number
// takes a multiply and a divide-by-ten step per digit via one 32x32 multiplier and two
// strobes. Configuration writes are always ready and must be issued while busy is low.
module char_lcd_nibble_sequencer import lcdseq_pkg::*; #(
    parameter int LINE_COLUMNS = 16,
    parameter int MAX_DIGITS   = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_byte_value,
    input  logic [1:0]  i_line,
    input  logic [7:0]  i_column,
    input  logic [31:0] i_number_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_wait_before_us,
    output logic        o_last
);

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [7:0]      r_byte;
    logic [7:0]      n_byte;
    logic [15:0]     r_power_wait;
    logic            r_eight_bit;
    logic            r_strobe;
    logic            r_rs;
    logic [3:0]      r_nibble;
    logic [15:0]     r_wait;
    logic            r_last;

    logic     w_accept;
    logic     w_cfg_we;
    logic     w_in_range;
    t_uword   w_uw;
    logic     w_jump;
    logic [7:0]  w_src;
    logic [15:0] w_wait;
    t_dig_ctl w_dctl;
    t_dig_sts w_dsts;

    assign w_accept    = i_start && !r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    // enable pulse width belongs to the strobe driver; no field here depends on it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_wait <= RST_POWER_WAIT;
            r_eight_bit  <= 1'b0;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE_PULSE: ;
                CFG_POWER_WAIT:   r_power_wait <= i_cfg_data;
                CFG_EIGHT_BIT:    r_eight_bit  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_in_range = i_column < 8'(LINE_COLUMNS);

    always_comb begin
        n_pc   = A_NULL;
        n_byte = i_byte_value;
        case (i_operation)
            OP_INIT:   n_pc = A_INIT;
            OP_CMD:    n_pc = A_CMD;
            OP_CHAR:   n_pc = A_CHAR;
            OP_CURSOR: begin
                if (w_in_range && i_line == 2'd1) begin
                    n_pc   = A_CMD;
                    n_byte = LCD_LINE1 + i_column;
                end else if (w_in_range && i_line == 2'd2) begin
                    n_pc   = A_CMD;
                    n_byte = LCD_LINE2 + i_column;
                end
            end
            OP_NUMBER: n_pc = A_NUM;
            default:   n_pc = A_NULL;
        endcase
    end

    assign w_uw = ucode(r_pc);

    always_comb begin
        case (w_uw.cond)
            C_NONE:      w_jump = 1'b0;
            C_ALWAYS:    w_jump = 1'b1;
            C_EIGHT:     w_jump = r_eight_bit;
            C_CONV_MORE: w_jump = w_dsts.conv_more;
            C_DIG_MORE:  w_jump = w_dsts.dig_more;
            default:     w_jump = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uw.src)
            SRC_CONST: w_src = w_uw.konst;
            SRC_BYTE:  w_src = r_byte;
            SRC_DIGIT: w_src = {ASCII_DIG_HI, w_dsts.digit};
            default:   w_src = w_uw.konst;
        endcase
    end

    always_comb begin
        case (w_uw.wt)
            WT_ZERO:  w_wait = 16'd0;
            WT_POWER: w_wait = r_power_wait;
            WT_SHORT: w_wait = WAIT_SHORT_US;
            WT_CLEAR: w_wait = WAIT_CLEAR_US;
            default:  w_wait = 16'd0;
        endcase
    end

    assign w_dctl.load = w_accept;
    assign w_dctl.mul  = r_busy && (w_uw.act == ACT_MUL);
    assign w_dctl.div  = r_busy && (w_uw.act == ACT_DIV);
    assign w_dctl.pop  = r_busy && (w_uw.act == ACT_POP);

    lcdseq_digits #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_digits (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number_value(i_number_value),
        .i_ctl         (w_dctl),
        .o_sts         (w_dsts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= A_NULL;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy && w_uw.emit;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pc   <= n_pc;
            end else if (r_busy) begin
                if (w_jump) begin
                    r_pc <= w_uw.target;
                end else if (w_uw.endp) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= r_pc + PC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= n_byte;
        end
        r_rs     <= w_uw.rs;
        r_nibble <= w_uw.hi ? w_src[7:4] : w_src[3:0];
        r_wait   <= w_wait;
        r_last   <= w_uw.last && !w_jump;
    end

    assign o_busy           = r_busy;
    assign o_strobe         = r_strobe;
    assign o_reg_select     = r_rs;
    assign o_nibble         = r_nibble;
    assign o_wait_before_us = r_wait;
    assign o_last           = r_last;

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !o_busy)
        else $error("final strobe while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_busy)
        else $error("non-final strobe after request ended");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted request did not start");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= A_NULL)
        else $error("program counter out of range");

endmodule
